// ----- rtl/sloc_pkg.sv -----
// Shared types, constants and helpers for the substring locator.
// Used by substring_locate_windows_core and its port checker.
package sloc_pkg;

  localparam int unsigned MAX_PATTERN_BYTES = 16;
  localparam int unsigned MAX_ROW_BYTES     = 65536;

  localparam int unsigned LEN_W   = 5;
  localparam int unsigned WIN_W   = $clog2(MAX_PATTERN_BYTES);
  localparam int unsigned POS_W   = $clog2(MAX_ROW_BYTES + 1);
  localparam int unsigned START_W = 16;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned IDX_W   = 3;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [IDX_W-1:0] {
    CFG_PAT_LO   = 3'd0,
    CFG_PAT_HI   = 3'd1,
    CFG_PAT_LEN  = 3'd2,
    CFG_FOLD     = 3'd3,
    CFG_FIND_ALL = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    KIND_MATCH   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    logic               kind;
    logic [START_W-1:0] match_start;
    logic               row_selected;
    logic               offset_overflow;
    logic               last;
  } result_t;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_CASE    = 8'h20;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
      r = c + ASCII_CASE;
    end
    return r;
  endfunction

endpackage

// ----- rtl/substring_locate_windows_core.sv -----
// Streaming non-overlapping substring locator, top level.
// Depends on sloc_pkg (types, constants, case folding).
//
// Usage:
//  - Input channel: one text byte per transfer (data_byte_i) with row_end_i on
//    the last byte of a row. in_valid_i / in_stall_o handshake.
//  - Output channel: result items (match report or end-of-row summary),
//    out_valid_o / out_stall_i handshake. last_o marks the final result of
//    one input byte; a byte gives zero, one or two results.
//  - Config port: cfg_valid_i / cfg_ready_o, index and 64-bit data. Always
//    ready; write only while the block is idle.
// Timing:
//  - A byte is registered at transfer, compared against the pattern in the
//    next cycle and its results enter a 4-entry result queue, which drives
//    the output channel.
//  - One byte per cycle sustained while the queue has room; the window
//    compare is combinational. A byte with both a match and a summary gives
//    two results, so a run of such bytes fills the queue and holds the input
//    back even without an output stall.
// Reset: clears the window, row state, queue and config to defaults
//  (pattern length 1, case folding and find-all off).
// Stall: a stalled result holds; the queue fills, then in_stall_o rises.
module substring_locate_windows_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          row_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          kind_o,
  output logic [sloc_pkg::START_W-1:0]  match_start_o,
  output logic                          row_selected_o,
  output logic                          offset_overflow_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sloc_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [sloc_pkg::CFG_W-1:0]    cfg_data_i
);

  // config registers
  logic [sloc_pkg::CFG_W-1:0] pat_lo_q, pat_hi_q;
  logic [sloc_pkg::LEN_W-1:0] pat_len_q;
  logic                       fold_q, find_all_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q   <= '0;
      pat_hi_q   <= '0;
      pat_len_q  <= sloc_pkg::LEN_W'(1);
      fold_q     <= 1'b0;
      find_all_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sloc_pkg::CFG_PAT_LO:   pat_lo_q   <= cfg_data_i;
        sloc_pkg::CFG_PAT_HI:   pat_hi_q   <= cfg_data_i;
        sloc_pkg::CFG_PAT_LEN:  pat_len_q  <= cfg_data_i[sloc_pkg::LEN_W-1:0];
        sloc_pkg::CFG_FOLD:     fold_q     <= cfg_data_i[0];
        sloc_pkg::CFG_FIND_ALL: find_all_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_end_q;
  logic       proc;

  assign in_stall_o = s1_valid_q && !proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_byte_q <= data_byte_i;
      s1_end_q  <= row_end_i;
    end
  end

  // row state
  logic [sloc_pkg::MAX_PATTERN_BYTES-1:0][7:0] win_q, win_d;
  logic [sloc_pkg::POS_W-1:0] pos_q, pos_d, nas_q, nas_d;
  logic                       hit_q, hit_d, povf_q, povf_d;

  logic [sloc_pkg::LEN_W-1:0] used_len;
  logic [sloc_pkg::WIN_W-1:0] len_m1;
  logic [2*sloc_pkg::CFG_W/8-1:0][7:0] pat_arr;
  logic [sloc_pkg::MAX_PATTERN_BYTES-1:0] pos_eq;
  logic                       win_match, row_full, long_enough, match;
  logic [sloc_pkg::POS_W-1:0] p_inc, start;
  logic                       wide;
  sloc_pkg::result_t          match_res, sum_res, first_res;
  logic [1:0]                 n_res;

  always_comb begin
    used_len = pat_len_q;
    if (pat_len_q == '0) begin
      used_len = sloc_pkg::LEN_W'(1);
    end else if (pat_len_q > sloc_pkg::LEN_W'(sloc_pkg::MAX_PATTERN_BYTES)) begin
      used_len = sloc_pkg::LEN_W'(sloc_pkg::MAX_PATTERN_BYTES);
    end
  end

  assign len_m1  = sloc_pkg::WIN_W'(used_len - sloc_pkg::LEN_W'(1));
  assign pat_arr = {pat_hi_q, pat_lo_q};
  assign win_d   = {win_q[sloc_pkg::MAX_PATTERN_BYTES-2:0], s1_byte_q};

  // window slot j (0 newest) pairs with pattern byte len-1-j
  always_comb begin
    for (int j = 0; j < sloc_pkg::MAX_PATTERN_BYTES; j++) begin
      pos_eq[j] = (sloc_pkg::LEN_W'(j) >= used_len) ||
                  (sloc_pkg::fold_byte(win_d[j], fold_q) ==
                   sloc_pkg::fold_byte(pat_arr[len_m1 - sloc_pkg::WIN_W'(j)], fold_q));
    end
  end

  assign win_match   = &pos_eq;
  assign row_full    = pos_q >= sloc_pkg::POS_W'(sloc_pkg::MAX_ROW_BYTES);
  assign p_inc       = pos_q + sloc_pkg::POS_W'(1);
  assign long_enough = p_inc >= sloc_pkg::POS_W'(used_len);
  assign start       = p_inc - sloc_pkg::POS_W'(used_len);
  assign wide        = start > sloc_pkg::POS_W'({sloc_pkg::START_W{1'b1}});
  assign match       = !row_full && long_enough && win_match && (start >= nas_q) &&
                       (find_all_q || !hit_q);

  always_comb begin
    match_res.kind            = sloc_pkg::KIND_MATCH;
    match_res.match_start     = wide ? {sloc_pkg::START_W{1'b1}}
                                     : start[sloc_pkg::START_W-1:0];
    match_res.row_selected    = 1'b1;
    match_res.offset_overflow = wide || povf_q;
    match_res.last            = !s1_end_q;

    sum_res.kind              = sloc_pkg::KIND_SUMMARY;
    sum_res.match_start       = '0;
    sum_res.row_selected      = hit_q || match;
    sum_res.offset_overflow   = povf_q || row_full;
    sum_res.last              = 1'b1;

    first_res = match ? match_res : sum_res;
    n_res     = {1'b0, match} + {1'b0, s1_end_q};
  end

  always_comb begin
    pos_d  = pos_q;
    nas_d  = nas_q;
    hit_d  = hit_q;
    povf_d = povf_q;
    if (row_full) begin
      povf_d = 1'b1;
    end else begin
      pos_d = p_inc;
      if (match) begin
        hit_d = 1'b1;
        nas_d = p_inc;
      end
    end
    if (s1_end_q) begin
      pos_d  = '0;
      nas_d  = '0;
      hit_d  = 1'b0;
      povf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      pos_q  <= '0;
      nas_q  <= '0;
      hit_q  <= 1'b0;
      povf_q <= 1'b0;
    end else if (proc) begin
      win_q  <= win_d;
      pos_q  <= pos_d;
      nas_q  <= nas_d;
      hit_q  <= hit_d;
      povf_q <= povf_d;
    end
  end

  // result queue
  sloc_pkg::result_t          fifo_q [sloc_pkg::FIFO_DEPTH];
  logic [sloc_pkg::PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [sloc_pkg::CNT_W-1:0] cnt_q;
  logic [sloc_pkg::CNT_W-1:0] free_slots;
  logic [1:0]                 push_n;
  logic                       pop;

  assign free_slots = sloc_pkg::CNT_W'(sloc_pkg::FIFO_DEPTH) - cnt_q;
  assign proc       = s1_valid_q && (free_slots >= sloc_pkg::CNT_W'(n_res));
  assign push_n     = proc ? n_res : 2'd0;
  assign pop        = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= first_res;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + sloc_pkg::PTR_W'(1)] <= sum_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + sloc_pkg::PTR_W'(push_n);
      rd_ptr_q <= rd_ptr_q + sloc_pkg::PTR_W'(pop);
      cnt_q    <= cnt_q + sloc_pkg::CNT_W'(push_n) - sloc_pkg::CNT_W'(pop);
    end
  end

  assign out_valid_o       = cnt_q != '0;
  assign kind_o            = fifo_q[rd_ptr_q].kind;
  assign match_start_o     = fifo_q[rd_ptr_q].match_start;
  assign row_selected_o    = fifo_q[rd_ptr_q].row_selected;
  assign offset_overflow_o = fifo_q[rd_ptr_q].offset_overflow;
  assign last_o            = fifo_q[rd_ptr_q].last;

endmodule

// ----- rtl/sloc_checker.sv -----
// Port-level checker for substring_locate_windows_core, plus its bind.
// Depends on sloc_pkg for the result kind codes and the start width.
module sloc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          kind_o,
  input logic [sloc_pkg::START_W-1:0]  match_start_o,
  input logic                          row_selected_o,
  input logic                          last_o
);

  // held result keeps its valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(match_start_o) && $stable(kind_o))
    else $error("stalled result changed");

  // a summary always closes the results of its byte
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == sloc_pkg::KIND_SUMMARY |-> last_o)
    else $error("summary without last");

  // match reports always flag the row and a non-final match is followed by a summary
  a_match_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == sloc_pkg::KIND_MATCH |-> row_selected_o)
    else $error("match report without row flag");

  a_summary_has_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && kind_o == sloc_pkg::KIND_MATCH && !last_o
    |=> out_valid_o && kind_o == sloc_pkg::KIND_SUMMARY && row_selected_o)
    else $error("summary after match missing or unflagged");

endmodule

bind substring_locate_windows_core sloc_checker u_sloc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .kind_o         (kind_o),
  .match_start_o  (match_start_o),
  .row_selected_o (row_selected_o),
  .last_o         (last_o)
);

// ----- tb/tb.sv -----
// Self-checking testbench for substring_locate_windows_core: byte rows in, match reports
// and row summaries out, checked against an in-bench predictor under random flow control.
// Depends on sloc_pkg and the core RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 1100;
  localparam int REPORT_CAP   = 200;

  // Predicts match reports and row summaries byte by byte, holds them until seen.
  class row_match_tracker;
    bit [63:0]         pat_lo;
    bit [63:0]         pat_hi;
    bit [4:0]          pat_len;
    bit                fold_on;
    bit                all_on;
    bit [7:0]          window [16];
    int unsigned       row_pos;
    int unsigned       free_from;
    bit                row_hit;
    bit                pos_ovf;
    sloc_pkg::result_t pending [$];
    int unsigned       fails;

    function new();
      pat_len = 5'd1;
    endfunction

    function void set_register(sloc_pkg::cfg_idx_e idx, bit [63:0] value);
      case (idx)
        sloc_pkg::CFG_PAT_LO:   pat_lo = value;
        sloc_pkg::CFG_PAT_HI:   pat_hi = value;
        sloc_pkg::CFG_PAT_LEN:  pat_len = value[4:0];
        sloc_pkg::CFG_FOLD:     fold_on = value[0];
        sloc_pkg::CFG_FIND_ALL: all_on = value[0];
        default: ;
      endcase
    endfunction

    function bit [7:0] norm(bit [7:0] c);
      if (fold_on && c >= 8'h41 && c <= 8'h5A) begin
        return c + 8'h20;
      end
      return c;
    endfunction

    function bit [7:0] pat_at(int i);
      bit [63:0] w;
      w = (i < 8) ? pat_lo : pat_hi;
      return w[(i % 8) * 8 +: 8];
    endfunction

    function void note_byte(bit [7:0] b, bit row_end);
      int                n;
      int unsigned       first;
      bit                same;
      sloc_pkg::result_t r;
      sloc_pkg::result_t outs [$];
      n = (pat_len == 0) ? 1 : ((pat_len > sloc_pkg::MAX_PATTERN_BYTES) ?
                                sloc_pkg::MAX_PATTERN_BYTES : pat_len);
      for (int k = 15; k > 0; k--) window[k] = window[k-1];
      window[0] = b;
      if (row_pos >= sloc_pkg::MAX_ROW_BYTES) begin
        pos_ovf = 1'b1;
      end else begin
        if (row_pos + 1 >= n) begin
          same = 1'b1;
          // newest byte sits at window[0], so pattern byte 0 lines up with window[n-1]
          for (int i = 0; i < n; i++) begin
            if (norm(window[n-1-i]) != norm(pat_at(i))) same = 1'b0;
          end
          first = row_pos + 1 - n;
          if (same && first >= free_from && (all_on || !row_hit)) begin
            r.kind            = sloc_pkg::KIND_MATCH;
            r.match_start     = (first > 16'hFFFF) ? 16'hFFFF : 16'(first);
            r.row_selected    = 1'b1;
            r.offset_overflow = (first > 16'hFFFF) || pos_ovf;
            r.last            = 1'b0;
            outs.push_back(r);
            row_hit   = 1'b1;
            free_from = row_pos + 1;
          end
        end
        row_pos++;
      end
      if (row_end) begin
        r.kind            = sloc_pkg::KIND_SUMMARY;
        r.match_start     = '0;
        r.row_selected    = row_hit;
        r.offset_overflow = pos_ovf;
        r.last            = 1'b0;
        outs.push_back(r);
        row_pos   = 0;
        free_from = 0;
        row_hit   = 1'b0;
        pos_ovf   = 1'b0;
      end
      if (outs.size() != 0) outs[outs.size()-1].last = 1'b1;
      foreach (outs[i]) pending.push_back(outs[i]);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      fails++;
      if (fails <= REPORT_CAP) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(sloc_pkg::result_t got);
      sloc_pkg::result_t want;
      if (pending.size() == 0) begin
        fails++;
        if (fails <= REPORT_CAP) begin
          $display("%0t: result with none expected, kind %0d start %0d", $time, got.kind,
                   got.match_start);
        end
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind) report("kind", want.kind, got.kind);
      if (got.match_start !== want.match_start)
        report("match_start", want.match_start, got.match_start);
      if (got.row_selected !== want.row_selected)
        report("row_selected", want.row_selected, got.row_selected);
      if (got.offset_overflow !== want.offset_overflow)
        report("offset_overflow", want.offset_overflow, got.offset_overflow);
      if (got.last !== want.last) report("last", want.last, got.last);
    endfunction
  endclass

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic [7:0]                   data_byte_i = '0;
  logic                         row_end_i   = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic                         kind_o;
  logic [sloc_pkg::START_W-1:0] match_start_o;
  logic                         row_selected_o;
  logic                         offset_overflow_o;
  logic                         last_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [sloc_pkg::IDX_W-1:0]   cfg_index_i = '0;
  logic [sloc_pkg::CFG_W-1:0]   cfg_data_i  = '0;

  row_match_tracker  tracker;
  sloc_pkg::result_t seen_result;

  // generator's view of the current pattern
  bit [7:0]    pat_bytes [16];
  int          pat_used = 1;
  int          burst_left;
  bit          gaps_on = 1'b1;
  int unsigned bytes_sent;
  int unsigned stall_tick;
  int          stall_mode;

  substring_locate_windows_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .row_end_i         (row_end_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .match_start_o     (match_start_o),
    .row_selected_o    (row_selected_o),
    .offset_overflow_o (offset_overflow_o),
    .last_o            (last_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stall pattern: one of four modes, redrawn at random
  always @(posedge clk_i) begin
    stall_tick++;
    if (stall_tick % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 2) == 0);
      2: out_stall_i <= ((stall_tick % 7) < 3);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_result = {kind_o, match_start_o, row_selected_o, offset_overflow_o, last_o};
      tracker.check_result(seen_result);
    end
  end

  task automatic send_byte(input bit [7:0] b, input bit row_end);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    row_end_i   <= row_end;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_byte(b, row_end);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], close && (i == s.len() - 1));
  endtask

  // stop input, wait for every expected result, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input sloc_pkg::cfg_idx_e idx, input bit [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_register(idx, value);
  endtask

  task automatic apply_config(input bit [63:0] lo, input bit [63:0] hi, input bit [4:0] len,
                              input bit fold, input bit all);
    settle();
    write_reg(sloc_pkg::CFG_PAT_LO, lo);
    write_reg(sloc_pkg::CFG_PAT_HI, hi);
    write_reg(sloc_pkg::CFG_PAT_LEN, 64'(len));
    write_reg(sloc_pkg::CFG_FOLD, 64'(fold));
    write_reg(sloc_pkg::CFG_FIND_ALL, 64'(all));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    for (int i = 0; i < 16; i++) pat_bytes[i] = (i < 8) ? lo[i*8 +: 8] : hi[(i-8)*8 +: 8];
    pat_used = (len == 0) ? 1 : ((len > 16) ? 16 : len);
  endtask

  function automatic bit [63:0] text_word(input string s);
    bit [63:0] w;
    w = '0;
    for (int i = 0; i < s.len() && i < 8; i++) w[i*8 +: 8] = s[i];
    return w;
  endfunction

  function automatic bit [7:0] case_jitter(input bit [7:0] b);
    if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A && $urandom_range(0, 4) == 0) begin
      return b ^ 8'h20;
    end
    return b;
  endfunction

  task automatic random_row(input int len, input bit close);
    bit [7:0] row_q [$];
    int       pick;
    while (row_q.size() < len) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        for (int i = 0; i < pat_used; i++) row_q.push_back(case_jitter(pat_bytes[i]));
      end else if (pick < 60) begin
        row_q.push_back(case_jitter(pat_bytes[$urandom_range(0, pat_used - 1)]));
      end else begin
        row_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (row_q[i]) send_byte(row_q[i], close && (i == row_q.size() - 1));
  endtask

  initial begin
    int unsigned start_count;
    int          rows;
    int          style;
    int          row_len;
    bit [63:0]   lo;
    bit [63:0]   hi;
    bit [4:0]    len;
    bit          open_tail;
    string       letters;

    tracker = new();
    letters = "abAB";
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: single byte 0x00 pattern, first match only
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    apply_config(text_word("ig"), '0, 5'd2, 1'b0, 1'b0);
    send_text("igi", 1'b1);
    // 'i' ending the last row must not pair with the 'g' opening this one
    send_text("gig", 1'b1);

    apply_config(text_word("ii"), '1, 5'd2, 1'b0, 1'b1);
    send_text("iii", 1'b1);

    // fold must leave '`' and '@' apart
    apply_config(text_word("I@"), '0, 5'd2, 1'b1, 1'b1);
    send_text("i@`@I@", 1'b1);

    // config change inside a row takes effect from the next byte
    send_text("zi", 1'b0);
    apply_config(text_word("ig"), '0, 5'd2, 1'b0, 1'b1);
    send_text("g", 1'b1);

    // length zero acts as one
    apply_config(64'hFF, '0, 5'd0, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);

    // length above the maximum acts as the full 16 bytes
    lo = {8'h41, 8'h7F, 8'h80, 8'hFF, 8'h00, 24'($urandom())};
    hi = {$urandom(), $urandom()};
    apply_config(lo, hi, 5'd31, 1'b0, 1'b1);
    for (int i = 0; i < 16; i++) send_byte(pat_bytes[i], i == 15);

    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      style = $urandom_range(0, 2);
      for (int i = 0; i < 16; i++) begin
        case (style)
          0: pat_bytes[i] = 8'($urandom_range(0, 255));
          1: pat_bytes[i] = letters[$urandom_range(0, 3)];
          default: pat_bytes[i] = 8'($urandom_range(8'h61, 8'h7A)) ^ ($urandom_range(0, 1) ?
                                  8'h20 : 8'h00);
        endcase
      end
      for (int i = 0; i < 8; i++) begin
        lo[i*8 +: 8] = pat_bytes[i];
        hi[i*8 +: 8] = pat_bytes[i+8];
      end
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
      end else begin
        len = 5'($urandom_range(1, 16));
      end
      apply_config(lo, hi, len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      gaps_on   = ($urandom_range(0, 3) != 0);
      rows      = $urandom_range(2, 8);
      open_tail = ($urandom_range(0, 3) == 0);
      for (int r = 0; r < rows; r++) begin
        row_len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
        random_row(row_len, !(open_tail && r == rows - 1));
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (tracker.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, tracker.pending.size());
      tracker.fails++;
    end
    if (tracker.fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
